// ===== hdl/ibmh_pkg.sv =====
package ibmh_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int KEY_BITS     = 32;
  localparam int VTX_W        = 10;
  localparam int CNT_W        = 11;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_SOURCE       = 1'b1;

  typedef logic [VTX_W-1:0]    vtx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [KEY_BITS-1:0] key_t;

  typedef enum logic [1:0] {
    MODE_INIT     = 2'd0,
    MODE_EXTRACT  = 2'd1,
    MODE_DECREASE = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_INCREASE = 2'd2,
    ST_ABSENT   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] mode;
    vtx_t       vertex;
    key_t       new_key;
  } in_item_t;

  typedef struct packed {
    vtx_t       min_vertex;
    key_t       min_key;
    logic [1:0] status;
    logic       now_empty;
  } out_item_t;

  typedef struct packed {
    vtx_t vertex;
    key_t key;
  } entry_t;

endpackage

// ===== hdl/ibmh_in_if.sv =====
interface ibmh_in_if;
  import ibmh_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ibmh_out_if.sv =====
interface ibmh_out_if;
  import ibmh_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/indexed_binary_min_heap.sv =====
// Channel  | Direction | Payload
// in_ch    | sink      | mode, vertex, new_key
// out_ch   | source    | min_vertex, min_key, status, now_empty
// cfg_*    | write     | vertex_count (index 0), source_vertex (index 1)
// One item is handled at a time; in_ch is ready only while the sequencer is idle.
// Init fills the first min(vertex_count, 1024) slots, then sifts the source up if it lies past slot 0.
// Extract sifts the last entry down from the root; decrease-key sifts the entry up from its slot.
// Each heap level costs one read of the single heap memory read port per entry compared.
// Reset is synchronous; it clears control state, sets vertex_count to 1024 and source_vertex to 0.
// The heap memories are not cleared. A finished result waits in the output register until out_ch takes it.
module indexed_binary_min_heap
  import ibmh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ibmh_in_if.sink    in_ch,
  ibmh_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic [10:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_EX_A, S_EX_B, S_EX_C, S_DN_A, S_DN_B, S_DN_C, S_DN_E,
    S_UP_A, S_UP_B, S_DK_A, S_DK_B, S_DK_C, S_FIN
  } state_t;

  state_t    state_r, state_nxt;
  cnt_t      vcount_r;
  vtx_t      src_r;
  cnt_t      live_r, live_nxt;
  cnt_t      n_r, n_nxt;
  vtx_t      at_r, at_nxt;
  entry_t    cur_r, cur_nxt;
  entry_t    cand_r, cand_nxt;
  vtx_t      cand_slot_r, cand_slot_nxt;
  logic      cand_ok_r, cand_ok_nxt;
  in_item_t  item_r, item_nxt;
  out_item_t res_r, res_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      out_valid_r, out_valid_nxt;

  entry_t heap_mem [MAX_VERTICES];
  vtx_t   pos_mem [MAX_VERTICES];
  entry_t heap_rd_r;
  vtx_t   pos_rd_r;
  logic   hw_we, pw_we;
  vtx_t   hw_addr, pw_addr, h_raddr, p_raddr;
  entry_t hw_data;
  vtx_t   pw_data;

  logic [11:0] l12, r12, live12;
  key_t        best_k;

  assign l12    = {1'b0, at_r, 1'b1};
  assign r12    = l12 + 12'd1;
  assign live12 = {1'b0, live_r};
  assign best_k = cand_ok_r ? cand_r.key : cur_r.key;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (hw_we) heap_mem[hw_addr] <= hw_data;
    if (pw_we) pos_mem[pw_addr] <= pw_data;
    heap_rd_r <= heap_mem[h_raddr];
    pos_rd_r  <= pos_mem[p_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    live_nxt      = live_r;
    n_nxt         = n_r;
    at_nxt        = at_r;
    cur_nxt       = cur_r;
    cand_nxt      = cand_r;
    cand_slot_nxt = cand_slot_r;
    cand_ok_nxt   = cand_ok_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    hw_we = 1'b0; hw_addr = at_r; hw_data = cur_r;
    pw_we = 1'b0; pw_addr = cur_r.vertex; pw_data = at_r;
    h_raddr = '0;
    p_raddr = item_r.vertex;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt = in_ch.data;
          res_nxt  = '0;
          unique case (mode_t'(in_ch.data.mode))
            MODE_INIT: begin
              n_nxt  = (vcount_r > cnt_t'(MAX_VERTICES)) ? cnt_t'(MAX_VERTICES) : vcount_r;
              at_nxt = '0;
              if (n_nxt == '0) begin
                live_nxt  = '0;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_FILL;
              end
            end
            MODE_EXTRACT: begin
              if (live_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_EX_A;
              end
            end
            MODE_DECREASE: state_nxt = S_DK_A;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_FILL: begin
        hw_we   = 1'b1;
        hw_addr = at_r;
        hw_data = '{vertex: at_r, key: (at_r == src_r) ? key_t'(0) : '1};
        pw_we   = 1'b1;
        pw_addr = at_r;
        pw_data = at_r;
        at_nxt  = at_r + vtx_t'(1);
        if ({1'b0, at_r} == n_r - cnt_t'(1)) begin
          live_nxt = n_r;
          if ({1'b0, src_r} < n_r && src_r != '0) begin
            cur_nxt   = '{vertex: src_r, key: '0};
            at_nxt    = src_r;
            state_nxt = S_UP_A;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_EX_A: begin
        h_raddr   = '0;
        state_nxt = S_EX_B;
      end
      S_EX_B: begin
        res_nxt.min_vertex = heap_rd_r.vertex;
        res_nxt.min_key    = heap_rd_r.key;
        live_nxt = live_r - cnt_t'(1);
        h_raddr  = live_nxt[VTX_W-1:0];
        state_nxt = (live_nxt == '0) ? S_FIN : S_EX_C;
      end
      S_EX_C: begin
        cur_nxt   = heap_rd_r;
        at_nxt    = '0;
        state_nxt = S_DN_A;
      end
      S_DN_A: begin
        h_raddr = l12[VTX_W-1:0];
        if (l12 < live12) begin
          state_nxt = S_DN_B;
        end else begin
          hw_we = 1'b1;
          pw_we = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_DN_B: begin
        cand_nxt      = heap_rd_r;
        cand_slot_nxt = l12[VTX_W-1:0];
        cand_ok_nxt   = heap_rd_r.key < cur_r.key;
        h_raddr       = r12[VTX_W-1:0];
        state_nxt     = (r12 < live12) ? S_DN_C : S_DN_E;
      end
      S_DN_C: begin
        if (heap_rd_r.key < best_k) begin
          cand_nxt      = heap_rd_r;
          cand_slot_nxt = r12[VTX_W-1:0];
          cand_ok_nxt   = 1'b1;
        end
        state_nxt = S_DN_E;
      end
      S_DN_E: begin
        hw_we = 1'b1;
        pw_we = 1'b1;
        if (cand_ok_r) begin
          hw_data   = cand_r;
          pw_addr   = cand_r.vertex;
          at_nxt    = cand_slot_r;
          state_nxt = S_DN_A;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_UP_A: begin
        h_raddr = (at_r - vtx_t'(1)) >> 1;
        if (at_r == '0) begin
          hw_we = 1'b1;
          pw_we = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_UP_B;
        end
      end
      S_UP_B: begin
        hw_we = 1'b1;
        pw_we = 1'b1;
        if (cur_r.key < heap_rd_r.key) begin
          hw_data   = heap_rd_r;
          pw_addr   = heap_rd_r.vertex;
          at_nxt    = (at_r - vtx_t'(1)) >> 1;
          state_nxt = S_UP_A;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DK_A: begin
        p_raddr   = item_r.vertex;
        state_nxt = S_DK_B;
      end
      S_DK_B: begin
        h_raddr = pos_rd_r;
        at_nxt  = pos_rd_r;
        if ({1'b0, pos_rd_r} < live_r) begin
          state_nxt = S_DK_C;
        end else begin
          res_nxt.status = ST_ABSENT;
          state_nxt = S_FIN;
        end
      end
      S_DK_C: begin
        if (heap_rd_r.vertex != item_r.vertex) begin
          res_nxt.status = ST_ABSENT;
          state_nxt = S_FIN;
        end else if (heap_rd_r.key < item_r.new_key) begin
          res_nxt.status = ST_INCREASE;
          state_nxt = S_FIN;
        end else begin
          cur_nxt   = '{vertex: item_r.vertex, key: item_r.new_key};
          state_nxt = S_UP_A;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_data_nxt           = res_r;
          out_data_nxt.now_empty = (live_r == '0);
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      vcount_r    <= cnt_t'(MAX_VERTICES);
      src_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_idx == REG_VERTEX_COUNT) vcount_r <= cfg_wdata;
      if (cfg_we && cfg_idx == REG_SOURCE) src_r <= cfg_wdata[VTX_W-1:0];
    end
    n_r         <= n_nxt;
    at_r        <= at_nxt;
    cur_r       <= cur_nxt;
    cand_r      <= cand_nxt;
    cand_slot_r <= cand_slot_nxt;
    cand_ok_r   <= cand_ok_nxt;
    item_r      <= item_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= cnt_t'(MAX_VERTICES))
    else $error("live count above capacity");

  a_down_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DN_A |-> {1'b0, at_r} < live_r)
    else $error("sift-down slot outside the heap");

  a_up_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UP_B |-> {1'b0, at_r} < live_r)
    else $error("sift-up slot outside the heap");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish step");

endmodule

// ===== test/indexed_binary_min_heap_tb.sv =====
`timescale 1ns / 100ps

module indexed_binary_min_heap_tb;
  import ibmh_pkg::*;

  localparam key_t KEY_INF          = '1;
  localparam int   STALL_LIMIT      = 20000;
  localparam int   RANDOM_ITEMS     = 900;

  typedef struct {
    bit         is_cfg;
    bit         typed;
    logic [1:0] mode;
    vtx_t       vertex;
    key_t       new_key;
    vtx_t       exp_vertex;
    key_t       exp_key;
    status_t    exp_status;
    logic       exp_empty;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [10:0] cfg_wdata;

  ibmh_in_if  in_ch ();
  ibmh_out_if out_ch ();

  indexed_binary_min_heap uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow heap that mirrors the block.
  vtx_t heap_vtx [MAX_VERTICES];
  key_t heap_key [MAX_VERTICES];
  vtx_t vtx_pos  [MAX_VERTICES];
  bit   pos_known [MAX_VERTICES];
  int   live;
  int   count_reg;
  int   source_reg;

  out_item_t pending_results [$];
  int   errors;
  int   accepted_in;
  int   accepted_out;
  int   idle_cycles;
  int   n_extract_ok;
  int   n_decrease_ok;
  int   n_errors_seen;
  int   n_inits;
  bit   no_idle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void swap_slots(int a, int b);
    vtx_t va;
    vtx_t vb;
    key_t ka;
    va = heap_vtx[a];
    vb = heap_vtx[b];
    ka = heap_key[a];
    vtx_pos[va] = vtx_t'(b);
    vtx_pos[vb] = vtx_t'(a);
    heap_vtx[a] = vb;
    heap_vtx[b] = va;
    heap_key[a] = heap_key[b];
    heap_key[b] = ka;
  endfunction

  function automatic void sift_down(int at);
    int best;
    int l;
    forever begin
      best = at;
      l = 2 * at + 1;
      if (l < live && heap_key[l] < heap_key[best]) best = l;
      if (l + 1 < live && heap_key[l + 1] < heap_key[best]) best = l + 1;
      if (best == at) return;
      swap_slots(at, best);
      at = best;
    end
  endfunction

  function automatic void sift_up(int at);
    int up;
    while (at > 0) begin
      up = (at - 1) / 2;
      if (!(heap_key[at] < heap_key[up])) return;
      swap_slots(at, up);
      at = up;
    end
  endfunction

  function automatic out_item_t heap_step(in_item_t item);
    out_item_t res;
    int n;
    int s;
    res = '0;
    res.status = ST_OK;
    case (item.mode)
      MODE_INIT: begin
        n = (count_reg > MAX_VERTICES) ? MAX_VERTICES : count_reg;
        for (int i = 0; i < n; i++) begin
          heap_vtx[i] = vtx_t'(i);
          heap_key[i] = KEY_INF;
          vtx_pos[i] = vtx_t'(i);
          pos_known[i] = 1'b1;
        end
        if (source_reg < n) heap_key[source_reg] = '0;
        live = n;
        for (int i = n / 2; i > 0; i--) sift_down(i - 1);
        n_inits++;
      end
      MODE_EXTRACT: begin
        if (live == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.min_vertex = heap_vtx[0];
          res.min_key = heap_key[0];
          live--;
          if (live > 0) begin
            heap_vtx[0] = heap_vtx[live];
            heap_key[0] = heap_key[live];
            vtx_pos[heap_vtx[0]] = '0;
            sift_down(0);
          end
          n_extract_ok++;
        end
      end
      MODE_DECREASE: begin
        s = vtx_pos[item.vertex];
        if (!(s < live && heap_vtx[s] == item.vertex)) begin
          res.status = ST_ABSENT;
        end else if (heap_key[s] < item.new_key) begin
          res.status = ST_INCREASE;
        end else begin
          heap_key[s] = item.new_key;
          sift_up(s);
          n_decrease_ok++;
        end
      end
      default: ;
    endcase
    if (res.status != ST_OK) n_errors_seen++;
    res.now_empty = (live == 0);
    return res;
  endfunction

  task automatic send_item(in_item_t item, bit typed, out_item_t typed_res);
    out_item_t predicted;
    while (!no_idle && $urandom_range(99) < 18) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      in_ch.data <= in_item_t'({$urandom, $urandom});
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data <= item;
    do @(posedge clk); while (!in_ch.ready);
    accepted_in++;
    predicted = heap_step(item);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_config(int vcount, int src);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_idx <= REG_VERTEX_COUNT;
    cfg_wdata <= 11'(vcount);
    @(negedge clk);
    cfg_idx <= REG_SOURCE;
    cfg_wdata <= 11'(src);
    @(negedge clk);
    cfg_we <= 1'b0;
    count_reg = vcount;
    source_reg = src;
  endtask

  function automatic in_item_t make_item(mode_t m, int v, key_t k);
    in_item_t it;
    it.mode = m;
    it.vertex = vtx_t'(v);
    it.new_key = k;
    return it;
  endfunction

  always @(negedge clk) begin
    out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      accepted_out++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: expected v=%0d k=%h st=%0d e=%0d, got v=%0d k=%h st=%0d e=%0d",
                     accepted_out, want.min_vertex, want.min_key, want.status,
                     want.now_empty, got.min_vertex, got.min_key, got.status,
                     got.now_empty);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [$];
    plan_row_t row;
    in_item_t item;
    out_item_t typed_res;
    int r;
    int s;
    int v;
    int phase;
    int ops;
    int sent;
    key_t cur;
    key_t k;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_VERTEX_COUNT;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    no_idle = 1'b0;
    errors = 0;
    accepted_in = 0;
    accepted_out = 0;
    idle_cycles = 0;
    n_extract_ok = 0;
    n_decrease_ok = 0;
    n_errors_seen = 0;
    n_inits = 0;
    live = 0;
    count_reg = MAX_VERTICES;
    source_reg = 0;
    for (int i = 0; i < MAX_VERTICES; i++) pos_known[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    plan.push_back('{0, 1, MODE_EXTRACT, 10'd1023, KEY_INF, 0, 0, ST_EMPTY, 1});
    plan.push_back('{0, 1, MODE_NONE, 0, 0, 0, 0, ST_OK, 1});
    plan.push_back('{1, 0, MODE_NONE, 5, 3, 0, 0, ST_OK, 0});
    plan.push_back('{0, 0, MODE_INIT, 0, 0, 0, 0, ST_OK, 0});
    plan.push_back('{0, 1, MODE_EXTRACT, 0, 0, 3, 0, ST_OK, 0});
    plan.push_back('{0, 0, MODE_DECREASE, 0, KEY_INF, 0, 0, ST_OK, 0});
    plan.push_back('{0, 0, MODE_DECREASE, 1, 0, 0, 0, ST_OK, 0});
    plan.push_back('{0, 1, MODE_DECREASE, 1, 5, 0, 0, ST_INCREASE, 0});
    plan.push_back('{0, 1, MODE_DECREASE, 3, 0, 0, 0, ST_ABSENT, 0});
    plan.push_back('{0, 0, MODE_DECREASE, 2, 0, 0, 0, ST_OK, 0});
    plan.push_back('{0, 0, MODE_DECREASE, 4, 32'h8000_0000, 0, 0, ST_OK, 0});
    for (int i = 0; i < 4; i++)
      plan.push_back('{0, 0, MODE_EXTRACT, 0, 0, 0, 0, ST_OK, 0});
    plan.push_back('{0, 1, MODE_EXTRACT, 0, 0, 0, 0, ST_EMPTY, 1});
    plan.push_back('{1, 0, MODE_NONE, 0, 0, 0, 0, ST_OK, 0});
    plan.push_back('{0, 1, MODE_INIT, 0, 0, 0, 0, ST_OK, 1});
    plan.push_back('{1, 0, MODE_NONE, 3, 7, 0, 0, ST_OK, 0});
    plan.push_back('{0, 0, MODE_INIT, 0, 0, 0, 0, ST_OK, 0});
    plan.push_back('{0, 1, MODE_EXTRACT, 0, 0, 0, KEY_INF, ST_OK, 0});
    plan.push_back('{0, 0, MODE_EXTRACT, 0, 0, 0, 0, ST_OK, 0});

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        write_config(row.vertex, row.new_key);
      end else begin
        typed_res.min_vertex = row.exp_vertex;
        typed_res.min_key = row.exp_key;
        typed_res.status = row.exp_status;
        typed_res.now_empty = row.exp_empty;
        send_item(make_item(mode_t'(row.mode), row.vertex, row.new_key), row.typed,
                  typed_res);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: write_config(2047, 1023);
        1: write_config(1, 0);
        2: write_config(1024, 1023);
        default: begin
          r = $urandom_range(99);
          if (r < 65) v = $urandom_range(40, 1);
          else if (r < 70) v = 0;
          else if (r < 73) v = 1024;
          else if (r < 76) v = $urandom_range(2047, 1025);
          else v = $urandom_range(200, 41);
          s = ($urandom_range(99) < 75 && v > 0) ?
              $urandom_range((v > 1024 ? 1024 : v) - 1, 0) : $urandom_range(1023, 0);
          write_config(v, s);
        end
      endcase
      send_item(make_item(MODE_INIT, $urandom, $urandom), 0, '0);
      sent++;
      ops = $urandom_range(70, 10);
      for (int j = 0; j < ops && sent < RANDOM_ITEMS; j++) begin
        no_idle = (sent >= 300 && sent < 450);
        r = $urandom_range(99);
        if (r < 48) begin
          item = make_item(MODE_EXTRACT, $urandom, $urandom);
        end else if (r < 90 && live > 0) begin
          s = $urandom_range(live - 1, 0);
          v = heap_vtx[s];
          cur = heap_key[s];
          r = $urandom_range(99);
          if (r < 55) k = (cur == 0) ? 0 : key_t'($urandom_range(cur, 0));
          else if (r < 65) k = cur;
          else if (r < 75) k = key_t'($urandom_range(7, 0));
          else if (r < 88) k = (cur == KEY_INF) ? cur : cur + 1;
          else k = $urandom;
          item = make_item(MODE_DECREASE, v, k);
        end else if (r < 96) begin
          v = $urandom_range(1023, 0);
          if (!pos_known[v]) continue;
          item = make_item(MODE_DECREASE, v, $urandom);
        end else if (r < 98) begin
          item = make_item(MODE_NONE, $urandom, $urandom);
        end else begin
          item = make_item(MODE_INIT, $urandom, $urandom);
        end
        send_item(item, 0, '0);
        sent++;
      end
      phase++;
    end
    no_idle = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);

    $display("Ran %0d items over %0d heap loads: %0d extracts, %0d decreases,",
             accepted_in, n_inits, n_extract_ok, n_decrease_ok);
    $display("%0d error statuses, %0d results checked, %0d mismatches.",
             n_errors_seen, accepted_out, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
